[rtl/core/adagrad_pkg.sv]
// ----------------------------------------------------------------------------
// AdaGrad update package
// Shared widths, register indexes and state codes of the update engine.
// ----------------------------------------------------------------------------
package adagrad_pkg;

  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 48;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_EPSILON       = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_COUNT  = 2'd2;

  localparam logic [0:0] OP_LOAD   = 1'b0;
  localparam logic [0:0] OP_UPDATE = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_DIV1  = 8'b0000_1000,
    ST_SQRT  = 8'b0001_0000,
    ST_DIV2  = 8'b0010_0000,
    ST_UPD   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

endpackage

[rtl/core/adagrad_div.sv]
// ----------------------------------------------------------------------------
// AdaGrad divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adagrad_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [adagrad_pkg::NUM_W-1:0]     num,
  input  logic [adagrad_pkg::DEN_W-1:0]     den,
  output logic                              busy,
  output logic [adagrad_pkg::NUM_W-1:0]     quo
);

  logic [adagrad_pkg::NUM_W-1:0] q;
  logic [adagrad_pkg::DEN_W-1:0] rem;
  logic [adagrad_pkg::DEN_W-1:0] dvs;
  logic [6:0]                    cnt;
  logic [adagrad_pkg::DEN_W:0]   rem_sh;
  logic [adagrad_pkg::DEN_W:0]   diff;
  logic                          ge;

  assign rem_sh = {rem, q[adagrad_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};
  assign quo    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 7'd63) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dvs <= den;
      cnt <= '0;
    end else if (busy) begin
      q   <= {q[adagrad_pkg::NUM_W-2:0], ge};
      rem <= ge ? diff[adagrad_pkg::DEN_W-1:0] : rem_sh[adagrad_pkg::DEN_W-1:0];
      cnt <= cnt + 7'd1;
    end
  end

endmodule

[rtl/core/adagrad_sqrt.sv]
// ----------------------------------------------------------------------------
// AdaGrad square root
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module adagrad_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] xs;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem, xs[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd31) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      xs   <= {xs[61:0], 2'b00};
      rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root <= {root[30:0], ge};
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

[rtl/core/adagrad_parameter_update_top.sv]
// ----------------------------------------------------------------------------
// AdaGrad parameter update engine
// Per-coordinate AdaGrad update with parameter and accumulator memories.
// ----------------------------------------------------------------------------
// A load word passes through READ and DONE; an update word passes through
// READ, DIV1, SQRT, DIV2, UPD and DONE, using the divider twice and the square
// root once. The result is registered on leaving DONE, which waits until the
// output register is free; the next word is accepted back in IDLE. One word is
// in work. After reset the accumulator memory is cleared, one entry per cycle,
// before the first word is accepted. Registers reset to their defaults.
module adagrad_parameter_update_top #(
  parameter int unsigned DIM = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [adagrad_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [adagrad_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [adagrad_pkg::IDX_W-1:0]       coord_index,
  input  logic signed [adagrad_pkg::VAL_W-1:0] value_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [adagrad_pkg::IDX_W-1:0]       coord_out,
  output logic signed [adagrad_pkg::VAL_W-1:0] param_value
);

  localparam int unsigned AW = (DIM > 1) ? $clog2(DIM) : 1;

  logic [31:0] learning_rate;
  logic [15:0] epsilon;
  logic [15:0] sample_count;

  adagrad_pkg::state_t state;

  logic [adagrad_pkg::VAL_W-1:0] pmem [DIM];
  logic [adagrad_pkg::ACC_W-1:0] amem [DIM];
  logic [adagrad_pkg::VAL_W-1:0] p_rd;
  logic [adagrad_pkg::ACC_W-1:0] a_rd;

  logic [AW-1:0]                 clr_cnt;
  logic                          op_r;
  logic [adagrad_pkg::IDX_W-1:0] idx_r;
  logic [adagrad_pkg::VAL_W-1:0] val_r;
  logic                          in_rng;
  logic [adagrad_pkg::ACC_W-1:0] acc_new;
  logic [adagrad_pkg::VAL_W-1:0] res;

  logic        accept;
  logic        out_free;
  logic [31:0] mag;
  logic [15:0] n_eff;
  logic [15:0] eps_eff;
  logic        div_start;
  logic [adagrad_pkg::NUM_W-1:0] div_num;
  logic [adagrad_pkg::DEN_W-1:0] div_den;
  logic        div_busy;
  logic [adagrad_pkg::NUM_W-1:0] div_quo;
  logic        sq_start;
  logic        sq_busy;
  logic [31:0] sq_root;
  logic [adagrad_pkg::ACC_W:0]   acc_sum;
  logic [adagrad_pkg::ACC_W-1:0] acc_sat;
  logic [33:0] step;
  logic signed [34:0] p_ext;
  logic signed [34:0] p_new;
  logic [31:0] p_sat;

  assign in_ready = (state == adagrad_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mag      = val_r[31] ? 32'(-val_r) : val_r;
  assign n_eff    = (sample_count == 16'd0) ? 16'd1 : sample_count;
  assign eps_eff  = (epsilon == 16'd0) ? 16'd1 : epsilon;

  assign acc_sum = {1'b0, a_rd} + {1'b0, div_quo[adagrad_pkg::ACC_W-1:0]};
  assign acc_sat = acc_sum[adagrad_pkg::ACC_W] ? '1 : acc_sum[adagrad_pkg::ACC_W-1:0];

  assign div_start = (state == adagrad_pkg::ST_READ && in_rng && op_r == adagrad_pkg::OP_UPDATE)
                  || (state == adagrad_pkg::ST_SQRT && !sq_busy);
  assign sq_start  = (state == adagrad_pkg::ST_DIV1 && !div_busy);

  always_comb begin
    if (state == adagrad_pkg::ST_READ) begin
      div_num = 64'(mag) * 64'(mag);
      div_den = {32'(n_eff) * 32'(n_eff), 16'd0};
    end else begin
      div_num = 64'(learning_rate) * 64'(mag);
      div_den = adagrad_pkg::DEN_W'(eps_eff) + adagrad_pkg::DEN_W'(sq_root);
    end
  end

  assign step  = (div_quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_quo[33:0];
  assign p_ext = {{3{p_rd[31]}}, p_rd};
  assign p_new = val_r[31] ? p_ext + $signed({1'b0, step}) : p_ext - $signed({1'b0, step});
  always_comb begin
    if (p_new > 35'sd2147483647) begin
      p_sat = 32'h7FFF_FFFF;
    end else if (p_new < -35'sd2147483648) begin
      p_sat = 32'h8000_0000;
    end else begin
      p_sat = p_new[31:0];
    end
  end

  adagrad_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  adagrad_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     ({acc_sat, 16'd0}),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 32'd655;
      epsilon       <= 16'd1;
      sample_count  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        adagrad_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data;
        adagrad_pkg::REG_EPSILON:       epsilon       <= cfg_data[15:0];
        adagrad_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_rd <= pmem[AW'(coord_index)];
      a_rd <= amem[AW'(coord_index)];
    end
    if (state == adagrad_pkg::ST_DONE && out_free && in_rng) begin
      pmem[AW'(idx_r)] <= res;
    end
    if (state == adagrad_pkg::ST_CLEAR) begin
      amem[clr_cnt] <= '0;
    end else if (state == adagrad_pkg::ST_DONE && out_free && in_rng) begin
      amem[AW'(idx_r)] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adagrad_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != adagrad_pkg::ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        adagrad_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DIM - 1)) begin
            state <= adagrad_pkg::ST_IDLE;
          end
        end
        adagrad_pkg::ST_IDLE: begin
          if (accept) begin
            state <= adagrad_pkg::ST_READ;
          end
        end
        adagrad_pkg::ST_READ: begin
          if (in_rng && op_r == adagrad_pkg::OP_UPDATE) begin
            state <= adagrad_pkg::ST_DIV1;
          end else begin
            state <= adagrad_pkg::ST_DONE;
          end
        end
        adagrad_pkg::ST_DIV1: begin
          if (!div_busy) begin
            state <= adagrad_pkg::ST_SQRT;
          end
        end
        adagrad_pkg::ST_SQRT: begin
          if (!sq_busy) begin
            state <= adagrad_pkg::ST_DIV2;
          end
        end
        adagrad_pkg::ST_DIV2: begin
          if (!div_busy) begin
            state <= adagrad_pkg::ST_UPD;
          end
        end
        adagrad_pkg::ST_UPD: begin
          state <= adagrad_pkg::ST_DONE;
        end
        adagrad_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= adagrad_pkg::ST_IDLE;
          end
        end
        default: state <= adagrad_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op;
      idx_r  <= coord_index;
      val_r  <= value_in;
      in_rng <= {22'd0, coord_index} < 32'(DIM);
    end
    if (state == adagrad_pkg::ST_READ) begin
      acc_new <= '0;
      res     <= in_rng ? val_r : '0;
    end
    if (state == adagrad_pkg::ST_DIV1 && !div_busy) begin
      acc_new <= acc_sat;
    end
    if (state == adagrad_pkg::ST_UPD) begin
      res <= p_sat;
    end
    if (state == adagrad_pkg::ST_DONE && out_free) begin
      coord_out   <= idx_r;
      param_value <= res;
    end
  end

endmodule

[verif/adagrad_parameter_update_top_tb.sv]
// ----------------------------------------------------------------------------
// AdaGrad update engine testbench
// Drives load and gradient words through the valid/ready input, predicts each
// updated parameter with a cycle-free model of the engine, and checks every
// result word in order across several register settings and idling phases.
// ----------------------------------------------------------------------------
module adagrad_parameter_update_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;
  localparam logic [adagrad_pkg::CFG_IW-1:0] REG_UNMAPPED = 2'd3;
  localparam longint unsigned ACC_SAT = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned STEP_CAP = 64'h2_0000_0000;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [0:0]                          op;
    logic [adagrad_pkg::IDX_W-1:0]       idx;
    logic signed [adagrad_pkg::VAL_W-1:0] val;
  } grad_word_t;

  typedef struct packed {
    logic [adagrad_pkg::IDX_W-1:0]       idx;
    logic signed [adagrad_pkg::VAL_W-1:0] val;
  } param_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [adagrad_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [adagrad_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] op = adagrad_pkg::OP_LOAD;
  logic [adagrad_pkg::IDX_W-1:0] coord_index = '0;
  logic signed [adagrad_pkg::VAL_W-1:0] value_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [adagrad_pkg::IDX_W-1:0] coord_out;
  logic signed [adagrad_pkg::VAL_W-1:0] param_value;

  adagrad_parameter_update_top #(.DIM(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .coord_index(coord_index), .value_in(value_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .coord_out(coord_out), .param_value(param_value)
  );

  always #5 clk = ~clk;

  grad_word_t   word_queue[$];
  param_word_t  param_expect[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_cnt = 0;
  logic         hold_start = 1'b0;
  bit           in_taken = 1'b0;

  logic [31:0] lr_reg = 32'd655;
  logic [15:0] eps_reg = 16'd1;
  logic [15:0] count_reg = 16'd1;
  logic signed [31:0] param_mem[DEPTH];
  longint unsigned acc_mem[DEPTH];

  bit gen_loaded[DEPTH];
  int unsigned loaded_list[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic param_word_t apply_word(grad_word_t w);
    param_word_t r;
    longint unsigned mag, n, eps, inc, acc, denom, step;
    longint p;
    r.idx = w.idx;
    if (w.op == adagrad_pkg::OP_LOAD) begin
      param_mem[w.idx] = w.val;
      acc_mem[w.idx] = 0;
    end else begin
      mag = (w.val < 0) ? longint'(-longint'(w.val)) : longint'(w.val);
      n = (count_reg == 0) ? 1 : count_reg;
      eps = (eps_reg == 0) ? 1 : eps_reg;
      inc = (mag * mag) / ((n * n) << 16);
      acc = acc_mem[w.idx];
      acc = (inc > ACC_SAT - acc) ? ACC_SAT : acc + inc;
      acc_mem[w.idx] = acc;
      denom = eps + int_sqrt(acc << 16);
      step = (longint'(lr_reg) * mag) / denom;
      if (step > STEP_CAP) step = STEP_CAP;
      p = longint'(param_mem[w.idx]);
      if (w.val < 0) p = p + longint'(step);
      else p = p - longint'(step);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      param_mem[w.idx] = p[31:0];
    end
    r.val = param_mem[w.idx];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Acceptance, prediction and result checking, all on the rising edge.
  always @(posedge clk) begin
    param_word_t got;
    param_word_t want;
    cycle_count++;
    in_taken = 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_taken = 1'b1;
      param_expect.push_back(apply_word('{op, coord_index, value_in}));
    end
    if (!rst && out_valid && out_ready) begin
      got = '{coord_out, param_value};
      if (param_expect.size() == 0) begin
        report_mismatch("unexpected word, coord", got.idx, -1);
      end else begin
        want = param_expect.pop_front();
        if (got.idx !== want.idx) report_mismatch("coord_out", got.idx, want.idx);
        if (got.val !== want.val) report_mismatch("param_value", got.val, want.val);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_cnt <= 2000;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(negedge clk) begin
    grad_word_t w;
    if (!rst && (!in_valid || in_taken)) begin
      if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_queue.pop_front();
        op <= w.op;
        coord_index <= w.idx;
        value_in <= w.val;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic queue_word(logic [0:0] o, int unsigned idx, logic [31:0] v);
    if (o == adagrad_pkg::OP_LOAD && !gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    word_queue.push_back('{o, idx[adagrad_pkg::IDX_W-1:0], v});
  endtask

  task automatic write_reg(logic [adagrad_pkg::CFG_IW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      adagrad_pkg::REG_LEARNING_RATE: lr_reg = data;
      adagrad_pkg::REG_EPSILON:       eps_reg = data[15:0];
      adagrad_pkg::REG_SAMPLE_COUNT:  count_reg = data[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (word_queue.size() > 0 || in_valid || param_expect.size() > 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_gradient();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return $urandom_range(65535) * (($urandom_range(1) != 0) ? 1 : -1);
    if (pick < 40) return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (pick < 45) return 32'd0;
    return $urandom;
  endfunction

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15 || loaded_list.size() == 0)
        queue_word(adagrad_pkg::OP_LOAD, $urandom_range(DEPTH - 1), $urandom);
      else
        queue_word(adagrad_pkg::OP_UPDATE,
                   loaded_list[$urandom_range(loaded_list.size() - 1)],
                   random_gradient());
    end
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      param_mem[i] = '0;
      acc_mem[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the register reset values.
    queue_word(adagrad_pkg::OP_LOAD, 0, 32'h8000_0000);
    queue_word(adagrad_pkg::OP_LOAD, 1023, 32'h7FFF_FFFF);
    queue_word(adagrad_pkg::OP_LOAD, 512, 32'd0);
    queue_word(adagrad_pkg::OP_UPDATE, 0, 32'h8000_0000);
    queue_word(adagrad_pkg::OP_UPDATE, 1023, 32'h7FFF_FFFF);
    queue_word(adagrad_pkg::OP_UPDATE, 512, 32'd0);
    queue_word(adagrad_pkg::OP_UPDATE, 512, 32'd1);
    queue_word(adagrad_pkg::OP_UPDATE, 512, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) queue_word(adagrad_pkg::OP_UPDATE, 1023, 32'h7FFF_FFFF);
    queue_word(adagrad_pkg::OP_LOAD, 1023, 32'h0001_0000);
    queue_word(adagrad_pkg::OP_UPDATE, 1023, 32'h8000_0000);
    wait_drained();

    write_reg(adagrad_pkg::REG_LEARNING_RATE, 32'hFFFF_FFFF);
    write_reg(adagrad_pkg::REG_EPSILON, 32'h0000_FFFF);
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, 32'h0000_FFFF);
    write_reg(REG_UNMAPPED, 32'h0000_0000);
    queue_word(adagrad_pkg::OP_LOAD, 7, 32'h7FFF_0000);
    queue_word(adagrad_pkg::OP_UPDATE, 7, 32'h8000_0000);
    queue_word(adagrad_pkg::OP_LOAD, 7, 32'h8000_0000);
    queue_word(adagrad_pkg::OP_UPDATE, 7, 32'h7FFF_FFFF);
    queue_word(adagrad_pkg::OP_UPDATE, 7, 32'h0000_0001);
    queue_random(270);
    wait_drained();

    write_reg(adagrad_pkg::REG_LEARNING_RATE, 32'd0);
    write_reg(adagrad_pkg::REG_EPSILON, 32'd0);
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, 32'd0);
    set_idling(68, 0);
    queue_random(270);
    wait_drained();

    write_reg(adagrad_pkg::REG_LEARNING_RATE, 32'h0001_0000);
    write_reg(adagrad_pkg::REG_EPSILON, 32'd1);
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, 32'd1);
    set_idling(0, 68);
    queue_random(270);
    wait_drained();

    // Receiver holds off while the sender keeps offering words.
    write_reg(adagrad_pkg::REG_LEARNING_RATE, 32'h0100_0000);
    write_reg(adagrad_pkg::REG_EPSILON, 32'd256);
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, 32'd4);
    set_idling(25, 25);
    queue_random(280);
    @(negedge clk);
    hold_start <= 1'b1;
    @(negedge clk);
    hold_start <= 1'b0;
    wait_drained();

    write_reg(adagrad_pkg::REG_LEARNING_RATE, $urandom);
    write_reg(adagrad_pkg::REG_EPSILON, $urandom_range(65535));
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, $urandom_range(1, 65535));
    set_idling(0, 0);
    queue_random(270);
    wait_drained();

    write_reg(adagrad_pkg::REG_LEARNING_RATE, 32'd655);
    write_reg(adagrad_pkg::REG_EPSILON, 32'd1);
    write_reg(adagrad_pkg::REG_SAMPLE_COUNT, 32'd3);
    set_idling(25, 68);
    queue_random(270);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && param_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (param_expect.size() != 0) report_mismatch("words left over", param_expect.size(), 0);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/adagrad_pkg.sv
rtl/core/adagrad_div.sv
rtl/core/adagrad_sqrt.sv
rtl/core/adagrad_parameter_update_top.sv
verif/adagrad_parameter_update_top_tb.sv
